[hw/rtl/msca_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// msca_pkg
// Shared types and constants for the minutes:seconds countdown timer with
// alarm: item codes, register indexes and the timer state record.
// ----------------------------------------------------------------------------
package msca_pkg;

	localparam logic [1:0] REQ_COUNT_TICK = 2'd0;
	localparam logic [1:0] REQ_ALARM_TICK = 2'd1;
	localparam logic [1:0] REQ_KNOB       = 2'd2;

	localparam logic [1:0] ROT_CW  = 2'd1;
	localparam logic [1:0] ROT_CCW = 2'd2;

	localparam logic [1:0] PRESS_SHORT = 2'd1;
	localparam logic [1:0] PRESS_LONG  = 2'd2;

	localparam logic CFG_ALARM_LENGTH = 1'b0;
	localparam logic CFG_MAX_MINUTES  = 1'b1;

	localparam logic [7:0] ALARM_LENGTH_RESET = 8'd20;
	localparam logic [6:0] MAX_MINUTES_RESET  = 7'd99;
	localparam logic [6:0] MINUTES_LIMIT      = 7'd99;
	localparam logic [5:0] SECONDS_TOP        = 6'd59;

	typedef struct packed {
		logic [1:0] req_type;
		logic [1:0] rotate;
		logic [1:0] press;
	} item_t;

	typedef struct packed {
		logic [6:0] minute_count;
		logic [5:0] second_count;
		logic       run_flag;
		logic       blink_flag;
		logic [7:0] alarm_count;
		logic       buzzer_level;
	} tmr_state_t;

endpackage
`default_nettype wire

[hw/rtl/msca_state.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// msca_state
// Timer state register and the combinational update for one registered item.
// ----------------------------------------------------------------------------
module msca_state
	import msca_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       en,
	input  wire item_t      item,
	input  wire logic [7:0] alarm_length,
	input  wire logic [6:0] max_minutes,
	output tmr_state_t      st_d
);

	tmr_state_t st_q;
	logic [6:0] lim;
	logic [7:0] alarm_dec;

	always_comb begin
		st_d      = st_q;
		lim       = (max_minutes > MINUTES_LIMIT) ? MINUTES_LIMIT : max_minutes;
		alarm_dec = (st_q.alarm_count != 8'd0) ? st_q.alarm_count - 8'd1 : 8'd0;
		case (item.req_type)
			REQ_COUNT_TICK: begin
				if (st_q.run_flag &&
				    (st_q.minute_count != 7'd0 || st_q.second_count != 6'd0)) begin
					st_d.blink_flag = 1'b0;
					if (st_q.second_count == 6'd0) begin
						st_d.minute_count = st_q.minute_count - 7'd1;
						st_d.second_count = SECONDS_TOP;
					end else begin
						st_d.second_count = st_q.second_count - 6'd1;
					end
					if (st_q.minute_count == 7'd0 && st_q.second_count == 6'd1) begin
						st_d.run_flag    = 1'b0;
						st_d.alarm_count = alarm_length;
					end
				end else if (!st_q.run_flag) begin
					st_d.blink_flag = 1'b1;
				end
			end
			REQ_ALARM_TICK: begin
				st_d.alarm_count  = alarm_dec;
				st_d.buzzer_level = alarm_dec[0];
			end
			REQ_KNOB: begin
				if (item.rotate == ROT_CW) begin
					if (st_d.minute_count >= lim) begin
						st_d.minute_count = lim;
					end else begin
						st_d.minute_count = st_d.minute_count + 7'd1;
					end
				end else if (item.rotate == ROT_CCW) begin
					if (st_d.minute_count == 7'd0) begin
						st_d.second_count = 6'd0;
					end else begin
						st_d.minute_count = st_d.minute_count - 7'd1;
					end
				end
				if (item.press == PRESS_SHORT) begin
					st_d.alarm_count = 8'd0;
					st_d.run_flag    = !st_d.run_flag && !(st_d.minute_count == 7'd0 &&
					                   st_d.second_count == 6'd0);
				end else if (item.press == PRESS_LONG) begin
					st_d.minute_count = 7'd0;
					st_d.second_count = 6'd0;
				end
			end
			default: begin
				st_d = st_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (en) begin
			st_q <= st_d;
		end
	end

`ifndef SYNTH
	a_seconds_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.second_count <= SECONDS_TOP)
		else $error("seconds count above 59");

	a_minutes_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.minute_count <= MINUTES_LIMIT)
		else $error("minutes count above 99");

	a_tick_clears_blink: assert property (@(posedge clk) disable iff (!arst_n)
		en && item.req_type == REQ_COUNT_TICK && st_q.run_flag &&
		(st_q.minute_count != 7'd0 || st_q.second_count != 6'd0) |=> !st_q.blink_flag)
		else $error("blink flag not cleared by a running count tick");

	a_alarm_tick_buzzer: assert property (@(posedge clk) disable iff (!arst_n)
		en && item.req_type == REQ_ALARM_TICK |=> st_q.buzzer_level == st_q.alarm_count[0])
		else $error("buzzer does not follow the alarm count after an alarm tick");
`endif

endmodule
`default_nettype wire

[hw/rtl/minute_second_countdown_alarm_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// minute_second_countdown_alarm_unit
// Minutes:seconds countdown timer with alarm, driven by count ticks, alarm
// ticks and knob events, with one result item per input item.
// ----------------------------------------------------------------------------
// Channel   Handshake              Payload
// in        in_valid / in_ready    req_type, rotate, press
// out       out_valid / out_ready  minutes, seconds, running, buzzer,
//                                  show_blink, alarm_active
// cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item is accepted per cycle while the output is not stalled; its result
// passes through the input register and then the result register.
// The state update is combinational between those two registers.
// A stalled output holds the result and the input register; in_ready drops
// only when both are full. Configuration writes are always taken.
// Reset clears the timer state and loads the register defaults.
// ----------------------------------------------------------------------------
module minute_second_countdown_alarm_unit
	import msca_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [1:0] req_type,
	input  wire logic [1:0] rotate,
	input  wire logic [1:0] press,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [6:0]      minutes,
	output logic [5:0]      seconds,
	output logic            running,
	output logic            buzzer,
	output logic            show_blink,
	output logic            alarm_active,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic       cfg_index,
	input  wire logic [7:0] cfg_data
);

	logic       valid_s1;
	item_t      item_s1;
	logic       adv;
	logic [7:0] alarm_length_q;
	logic [6:0] max_minutes_q;
	tmr_state_t st_d;

	assign adv       = valid_s1 && (!out_valid || out_ready);
	assign in_ready  = !valid_s1 || adv;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alarm_length_q <= ALARM_LENGTH_RESET;
			max_minutes_q  <= MAX_MINUTES_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_ALARM_LENGTH: alarm_length_q <= cfg_data;
				CFG_MAX_MINUTES:  max_minutes_q  <= cfg_data[6:0];
				default:          alarm_length_q <= alarm_length_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= '{req_type: req_type, rotate: rotate, press: press};
		end
	end

	msca_state u_state (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (adv),
		.item         (item_s1),
		.alarm_length (alarm_length_q),
		.max_minutes  (max_minutes_q),
		.st_d         (st_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			minutes      <= st_d.minute_count;
			seconds      <= st_d.second_count;
			running      <= st_d.run_flag;
			buzzer       <= st_d.buzzer_level;
			show_blink   <= !st_d.run_flag && st_d.blink_flag && (st_d.second_count != 6'd0);
			alarm_active <= st_d.alarm_count != 8'd0;
		end
	end

endmodule
`default_nettype wire
